FILE: rtl/u8sd_pkg.sv
package u8sd_pkg;

   localparam int ByteW    = 8;
   localparam int CpW      = 21;
   localparam int CountW   = 3;
   localparam int MaxBytes = 4;

   localparam logic [CpW-1:0] ReplacementChar = 21'h00FFFD;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef logic [MaxBytes-1:0][ByteW-1:0] bytes_type;

   // Outcome of one decode step on the front of the byte window.
   typedef struct packed {
      logic              emit;
      logic [CpW-1:0]    code_point;
      logic              replaced;
      logic              run_end;
      logic [CountW-1:0] rem_count;
      bytes_type         rem_bytes;
   } step_type;

   // Sequence length that a lead byte announces; zero when it cannot lead.
   function automatic logic [CountW-1:0] lead_length(input logic [ByteW-1:0] b);
      logic [CountW-1:0] len;
      len = 3'd0;
      if ((b & 8'h80) == 8'h00) begin
         len = 3'd1;
      end else if ((b & 8'hE0) == 8'hC0) begin
         len = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
         len = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
         len = 3'd4;
      end
      return len;
   endfunction

endpackage

FILE: rtl/u8sd_req_if.sv
interface u8sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       string_last;

   modport source (output valid, output byte_in, output string_last, input ready);
   modport sink (input valid, input byte_in, input string_last, output ready);
endinterface

FILE: rtl/u8sd_rsp_if.sv
interface u8sd_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        replaced;
   logic        string_end;
   logic        run_end;

   modport source (output valid, output code_point, output replaced, output string_end,
                   output run_end, input ready);
   modport sink (input valid, input code_point, input replaced, input string_end,
                 input run_end, output ready);
endinterface

FILE: rtl/u8sd_step.sv
module u8sd_step (
   input  u8sd_pkg::bytes_type                window,
   input  logic [u8sd_pkg::CountW-1:0]        count,
   input  logic                               last,
   output u8sd_pkg::step_type                 step
);

   logic [u8sd_pkg::CountW-1:0] len;
   logic [u8sd_pkg::CountW-1:0] used;
   logic [u8sd_pkg::CountW-1:0] next_len;
   logic [u8sd_pkg::CountW-1:0] rem;
   logic [2:0]                  cont_ok;
   logic                        bad;
   u8sd_pkg::bytes_type         shifted;

   always_comb begin
      len = u8sd_pkg::lead_length(window[0]);
      for (int i = 1; i < u8sd_pkg::MaxBytes; i++) begin
         cont_ok[i-1] = (window[i] & 8'hC0) == 8'h80;
      end
      bad = (len >= 3'd2 && !cont_ok[0]) || (len >= 3'd3 && !cont_ok[1]) ||
            (len == 3'd4 && !cont_ok[2]);

      step.emit       = 1'b1;
      step.replaced   = 1'b1;
      step.code_point = u8sd_pkg::ReplacementChar;
      used            = 3'd1;

      if (len == 3'd1) begin
         step.replaced   = 1'b0;
         step.code_point = {13'd0, window[0]};
      end else if (len == 3'd0) begin
         used = 3'd1;
      end else if (count < len) begin
         // A short sequence waits for more bytes unless the string ends here,
         // in which case the whole tail becomes one replacement.
         if (last) begin
            used = count;
         end else begin
            step.emit = 1'b0;
            used      = 3'd0;
         end
      end else if (!bad) begin
         step.replaced = 1'b0;
         used          = len;
         case (len)
            3'd2: begin
               step.code_point = {10'd0, window[0][4:0], window[1][5:0]};
            end
            3'd3: begin
               step.code_point = {5'd0, window[0][3:0], window[1][5:0], window[2][5:0]};
            end
            default: begin
               step.code_point = {window[0][2:0], window[1][5:0], window[2][5:0],
                                  window[3][5:0]};
            end
         endcase
      end

      case (used)
         3'd1:    shifted = {8'h00, window[3:1]};
         3'd2:    shifted = {16'h0000, window[3:2]};
         3'd3:    shifted = {24'h000000, window[3]};
         3'd4:    shifted = '0;
         default: shifted = window;
      endcase

      rem      = count - used;
      next_len = u8sd_pkg::lead_length(shifted[0]);

      // The result is the last for this byte when nothing is left, or when
      // what is left is a sequence that must wait for more bytes.
      step.run_end   = (rem == 3'd0) ||
                       (!last && next_len >= 3'd2 && rem < next_len);
      step.rem_count = rem;
      step.rem_bytes = shifted;
   end

endmodule

FILE: rtl/utf8_stream_decoder_top.sv
// A byte that is accepted is written into the held window; the shared decode step then
// registers its first code point onto the rsp channel once the channel can take a result,
// and registers each further code point it releases in turn. A byte is taken only in the idle
// state; no new byte is taken in the run state, which ends when a held byte must wait or the run ends.
// Reset clears the sequencer, the held-byte count and the result valid; held bytes and
// payload registers are left as they are.
module utf8_stream_decoder_top (
   input logic          clock,
   input logic          reset,
   u8sd_req_if.sink     req_chan,
   u8sd_rsp_if.source   rsp_chan
);

   u8sd_pkg::state_type               state_ff, state_in;
   u8sd_pkg::bytes_type               held_ff, held_in;
   logic [u8sd_pkg::CountW-1:0]       count_ff, count_in;
   logic                              last_ff, last_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [u8sd_pkg::CpW-1:0]          code_point_ff, code_point_in;
   logic                              replaced_ff, replaced_in;
   logic                              string_end_ff, string_end_in;
   logic                              run_end_ff, run_end_in;
   logic                              can_load;
   logic                              load_rsp;
   u8sd_pkg::step_type                step;

   u8sd_step u_step (
      .window (held_ff),
      .count  (count_ff),
      .last   (last_ff),
      .step   (step)
   );

   assign can_load = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         u8sd_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = u8sd_pkg::ST_RUN;
            end
         end
         u8sd_pkg::ST_RUN: begin
            if (!step.emit || (can_load && step.run_end)) begin
               state_in = u8sd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = u8sd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      held_in        = held_ff;
      count_in       = count_ff;
      last_in        = last_ff;
      load_rsp       = 1'b0;
      req_chan.ready = 1'b0;
      case (state_ff)
         u8sd_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               held_in[count_ff[1:0]] = req_chan.byte_in;
               count_in               = count_ff + 3'd1;
               last_in                = req_chan.string_last;
            end
         end
         u8sd_pkg::ST_RUN: begin
            if (step.emit && can_load) begin
               load_rsp = 1'b1;
               held_in  = step.rem_bytes;
               count_in = step.rem_count;
            end
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase

      rsp_valid_in  = load_rsp || (rsp_valid_ff && !rsp_chan.ready);
      code_point_in = load_rsp ? step.code_point : code_point_ff;
      replaced_in   = load_rsp ? step.replaced : replaced_ff;
      string_end_in = load_rsp ? (last_ff && step.run_end) : string_end_ff;
      run_end_in    = load_rsp ? step.run_end : run_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= u8sd_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff       <= held_in;
      last_ff       <= last_in;
      code_point_ff <= code_point_in;
      replaced_ff   <= replaced_in;
      string_end_ff <= string_end_in;
      run_end_ff    <= run_end_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.code_point = code_point_ff;
   assign rsp_chan.replaced   = replaced_ff;
   assign rsp_chan.string_end = string_end_ff;
   assign rsp_chan.run_end    = run_end_ff;

endmodule
